// File: hw/rtl/rpct_pkg.sv
// ----------------------------------------------------------------------------
// rpct_pkg
// shared widths, codes and control structs of the receive port completion
// table
// ----------------------------------------------------------------------------
package rpct_pkg;

	localparam int OP_W   = 2;
	localparam int ADDR_W = 32;
	localparam int LEN_W  = 24;
	localparam int TAG_W  = 32;
	localparam int STS_W  = 2;

	typedef logic [OP_W-1:0]  op_t;
	typedef logic [STS_W-1:0] sts_code_t;

	// item op codes
	localparam op_t OP_ALLOC  = 2'd0;
	localparam op_t OP_STORE  = 2'd1;
	localparam op_t OP_FREE   = 2'd2;
	localparam op_t OP_UNUSED = 2'd3;

	// result status codes
	localparam sts_code_t STS_OK        = 2'd0;
	localparam sts_code_t STS_FULL      = 2'd1;
	localparam sts_code_t STS_NOT_FOUND = 2'd2;
	localparam sts_code_t STS_OVERRUN   = 2'd3;

	// one table entry as held in the entry memory
	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [LEN_W-1:0]  received;
		logic [LEN_W-1:0]  expected;
		logic [TAG_W-1:0]  handler;
		logic [TAG_W-1:0]  context_tag;
	} entry_t;

	// scan request from the sequencer
	typedef struct packed {
		logic              start;
		op_t               op;
		logic [ADDR_W-1:0] key;
	} scan_cmd_t;

	// scan outcome, done is a one-cycle pulse
	typedef struct packed {
		logic done;
		logic hit;
	} scan_sts_t;

	// entry update at the end of an item
	typedef struct packed {
		logic mem_we;
		logic set_live;
		logic clr_live;
	} upd_cmd_t;

endpackage

// File: hw/rtl/rpct_req_if.sv
// ----------------------------------------------------------------------------
// rpct_req_if
// request channel: valid/ready handshake carrying one request item
// ----------------------------------------------------------------------------
interface rpct_req_if;
	import rpct_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [ADDR_W-1:0] address;
	logic [LEN_W-1:0]  byte_len;
	logic [TAG_W-1:0]  handler_tag;
	logic [TAG_W-1:0]  user_context;

	modport source (
		output valid, op, address, byte_len, handler_tag, user_context,
		input  ready
	);

	modport sink (
		input  valid, op, address, byte_len, handler_tag, user_context,
		output ready
	);

endinterface

// File: hw/rtl/rpct_rsp_if.sv
// ----------------------------------------------------------------------------
// rpct_rsp_if
// response channel: valid/ready handshake carrying one result item
// ----------------------------------------------------------------------------
interface rpct_rsp_if;
	import rpct_pkg::*;

	logic              valid;
	logic              ready;
	logic [STS_W-1:0]  status;
	logic [ADDR_W-1:0] port_id;
	logic              complete;
	logic [TAG_W-1:0]  done_handler;
	logic [TAG_W-1:0]  done_context;

	modport source (
		output valid, status, port_id, complete, done_handler, done_context,
		input  ready
	);

	modport sink (
		input  valid, status, port_id, complete, done_handler, done_context,
		output ready
	);

endinterface

// File: hw/rtl/rpct_table.sv
// ----------------------------------------------------------------------------
// rpct_table
// entry memory, live bits and the sequential lowest-index match scan
// ----------------------------------------------------------------------------
module rpct_table #(
	parameter int NUM_PORTS = 128
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  rpct_pkg::scan_cmd_t                     cmd,
	output rpct_pkg::scan_sts_t                     sts,
	output logic [((NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1)-1:0] hit_idx,
	output rpct_pkg::entry_t                        hit_entry,
	input  rpct_pkg::upd_cmd_t                      upd,
	input  logic [((NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1)-1:0] upd_idx,
	input  rpct_pkg::entry_t                        upd_entry
);
	import rpct_pkg::*;

	localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int CNT_W = $clog2(NUM_PORTS + 1);

	entry_t              entry_mem [NUM_PORTS];
	logic [NUM_PORTS-1:0] live_q;

	logic                busy_q;
	logic [CNT_W-1:0]    cnt_q;
	op_t                 op_q;
	logic [ADDR_W-1:0]   key_q;

	logic                vld_s1;
	logic                live_s1;
	logic [IDX_W-1:0]    idx_s1;
	entry_t              rd_s1;

	logic [IDX_W-1:0]    rd_idx;
	logic [ADDR_W-1:0]   next_addr;
	logic                match;
	logic                hit_now;
	logic                miss_now;
	logic                issue;

	assign rd_idx = cnt_q[IDX_W-1:0];

	// address the next store of this entry must carry
	assign next_addr = rd_s1.base + {{(ADDR_W-LEN_W){1'b0}}, rd_s1.received};

	always_comb begin
		unique case (op_q)
			OP_ALLOC: match = !live_s1;
			OP_STORE: match = live_s1 && (next_addr == key_q);
			OP_FREE:  match = live_s1 && (rd_s1.base == key_q);
			default:  match = 1'b0;
		endcase
	end

	assign hit_now  = busy_q && vld_s1 && match;
	assign miss_now = busy_q && !vld_s1 && (cnt_q == CNT_W'(NUM_PORTS));
	assign issue    = busy_q && !hit_now && (cnt_q < CNT_W'(NUM_PORTS));

	assign sts.done  = hit_now || miss_now;
	assign sts.hit   = hit_now;
	assign hit_idx   = idx_s1;
	assign hit_entry = rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else if (hit_now || miss_now) begin
			busy_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else if (busy_q) begin
			vld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// live bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
		end else if (upd.set_live) begin
			live_q[upd_idx] <= 1'b1;
		end else if (upd.clr_live) begin
			live_q[upd_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= cmd.op;
			key_q <= cmd.key;
		end
		if (issue) begin
			idx_s1  <= rd_idx;
			live_s1 <= live_q[rd_idx];
		end
	end

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (upd.mem_we) begin
			entry_mem[upd_idx] <= upd_entry;
		end
		if (issue) begin
			rd_s1 <= entry_mem[rd_idx];
		end
	end

endmodule

// File: hw/rtl/receive_port_completion_table_top.sv
// ----------------------------------------------------------------------------
// receive_port_completion_table_top
// receive port table: allocate, store-arrival and free items, one result each
// ----------------------------------------------------------------------------
// usage
// - req channel takes one item: op, address, byte_len, handler_tag and
//   user_context; rsp channel returns exactly one result item per request
// - allocate claims the lowest free entry, store adds bytes to the lowest
//   live entry whose base plus received count equals the address, free
//   releases the lowest live entry with that base
// - the entry memory is read one entry per cycle by a single scan unit; an
//   item that hits entry k has its result registered once the scan has read
//   entries 0 to k, a miss or a full table once it has read all NUM_PORTS
// - the unused op code skips the scan and goes straight to the update step,
//   which registers its not found result
// - req.ready is high only in the idle state, so the next item is accepted
//   only after the last one has left the update step; a finished result
//   sits in the output register and the next item can be accepted while it
//   waits
// - if rsp stalls, the following item finishes its scan and then holds in
//   the update step until the output register frees
// - reset clears the live bits and the control state; the entry memory
//   itself is not cleared and needs no pass after reset
// ----------------------------------------------------------------------------
module receive_port_completion_table_top #(
	parameter int NUM_PORTS = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	rpct_req_if.sink   req,
	rpct_rsp_if.source rsp
);
	import rpct_pkg::*;

	localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_ACT  = 2'd2;

	logic [1:0]        state_q;
	logic              hit_q;

	// latched request item
	op_t               op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;
	logic [TAG_W-1:0]  tag_q;
	logic [TAG_W-1:0]  ctx_q;

	// output register
	logic              rsp_valid_q;
	sts_code_t         status_q;
	logic [ADDR_W-1:0] port_id_q;
	logic              complete_q;
	logic [TAG_W-1:0]  handler_q;
	logic [TAG_W-1:0]  context_q;

	scan_cmd_t         cmd;
	scan_sts_t         sts;
	upd_cmd_t          upd;
	logic [IDX_W-1:0]  hit_idx;
	entry_t            hit_entry;
	entry_t            upd_entry;

	logic              accept;
	logic              go_act;
	logic [LEN_W:0]    sum;
	logic              over;
	logic              fill;

	sts_code_t         res_status;
	logic [ADDR_W-1:0] res_port;
	logic              res_complete;
	logic [TAG_W-1:0]  res_handler;
	logic [TAG_W-1:0]  res_context;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	// the update step waits for a free output register
	assign go_act = (state_q == ST_ACT) && (!rsp_valid_q || rsp.ready);

	// unused op codes skip the scan
	assign cmd.start = accept && (req.op != OP_UNUSED);
	assign cmd.op    = req.op;
	assign cmd.key   = req.address;

	rpct_table #(
		.NUM_PORTS (NUM_PORTS)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.hit_idx   (hit_idx),
		.hit_entry (hit_entry),
		.upd       (upd),
		.upd_idx   (hit_idx),
		.upd_entry (upd_entry)
	);

	// new received count, one bit wider to catch the overrun
	assign sum  = {1'b0, hit_entry.received} + {1'b0, len_q};
	assign over = sum > {1'b0, hit_entry.expected};
	assign fill = sum == {1'b0, hit_entry.expected};

	// result and entry update of the finished scan
	always_comb begin
		res_status   = STS_NOT_FOUND;
		res_port     = '0;
		res_complete = 1'b0;
		res_handler  = '0;
		res_context  = '0;
		upd          = '0;
		upd_entry    = hit_entry;
		unique case (op_q)
			OP_ALLOC: begin
				upd_entry.base        = addr_q;
				upd_entry.received    = '0;
				upd_entry.expected    = len_q;
				upd_entry.handler     = tag_q;
				upd_entry.context_tag = ctx_q;
				if (hit_q) begin
					res_status   = STS_OK;
					res_port     = addr_q;
					upd.mem_we   = go_act;
					upd.set_live = go_act;
				end else begin
					res_status = STS_FULL;
				end
			end
			OP_STORE: begin
				upd_entry.received = sum[LEN_W-1:0];
				if (hit_q) begin
					res_port = hit_entry.base;
					if (over) begin
						res_status = STS_OVERRUN;
					end else begin
						res_status = STS_OK;
						upd.mem_we = go_act;
						if (fill) begin
							res_complete = 1'b1;
							res_handler  = hit_entry.handler;
							res_context  = hit_entry.context_tag;
						end
					end
				end
			end
			OP_FREE: begin
				if (hit_q) begin
					res_status   = STS_OK;
					res_port     = addr_q;
					upd.clr_live = go_act;
				end
			end
			default: begin
				res_status = STS_NOT_FOUND;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hit_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hit_q   <= 1'b0;
						state_q <= (req.op == OP_UNUSED) ? ST_ACT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.done) begin
						hit_q   <= sts.hit;
						state_q <= ST_ACT;
					end
				end
				ST_ACT: begin
					if (go_act) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.op;
			addr_q <= req.address;
			len_q  <= req.byte_len;
			tag_q  <= req.handler_tag;
			ctx_q  <= req.user_context;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (go_act) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_act) begin
			status_q   <= res_status;
			port_id_q  <= res_port;
			complete_q <= res_complete;
			handler_q  <= res_handler;
			context_q  <= res_context;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.port_id      = port_id_q;
	assign rsp.complete     = complete_q;
	assign rsp.done_handler = handler_q;
	assign rsp.done_context = context_q;

	// scan outcome only while the sequencer waits for it
	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> (state_q == ST_SCAN))
		else $error("scan finished outside the scan state");

	// entries change only in the update step
	a_upd_in_act: assert property (@(posedge clk) disable iff (!arst_n)
		(upd.mem_we || upd.set_live || upd.clr_live) |-> go_act)
		else $error("entry update outside the update step");

	// a finished item always lands in the output register
	a_rsp_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		go_act |=> rsp_valid_q)
		else $error("result lost after update step");

	// completion is only ever reported with an ok status
	a_complete_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && complete_q) |-> (status_q == STS_OK))
		else $error("completion reported with an error status");

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the receive port completion table: a short table
// of directed items, then shaped random allocate/store/free traffic, every
// result checked in order against its hand-typed value or a port table predictor kept in the bench
// ----------------------------------------------------------------------------
module tb_top;
	import rpct_pkg::*;

	localparam int NUM_PORTS        = 128;
	localparam int DIR_N            = 23;
	localparam int RANDOM_ITEMS     = 1200;
	// one long receiver hold-off, in cycles after reset, so the block backs up
	// into the request side
	localparam int PRESSURE_AT      = 5000;
	localparam int PRESSURE_CYCLES  = 2000;
	// timeout, several times the slowest run of about 1250 items
	localparam int TIMEOUT_CYCLES   = 1_000_000;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] address;
		logic [LEN_W-1:0]  byte_len;
		logic [TAG_W-1:0]  handler_tag;
		logic [TAG_W-1:0]  user_context;
	} req_item_t;

	typedef struct packed {
		sts_code_t         status;
		logic [ADDR_W-1:0] port_id;
		logic              complete;
		logic [TAG_W-1:0]  done_handler;
		logic [TAG_W-1:0]  done_context;
	} rsp_item_t;

	// typed marks a row whose result is written out by hand
	typedef struct packed {
		req_item_t stim;
		logic      typed;
		rsp_item_t want;
	} dir_row_t;

	localparam rsp_item_t NO_RSP = '0;

	// directed items, walked in order from an empty table
	localparam dir_row_t DIRECTED_ROWS [DIR_N] = '{
		// free and store on an empty table miss
		'{'{OP_FREE, 32'h0, 24'h0, 32'h0, 32'h0}, 1'b1,
			'{STS_NOT_FOUND, 32'h0, 1'b0, 32'h0, 32'h0}},
		'{'{OP_STORE, 32'h0, 24'h0, 32'h0, 32'h0}, 1'b1,
			'{STS_NOT_FOUND, 32'h0, 1'b0, 32'h0, 32'h0}},
		// unused op code with every field at its top value
		'{'{OP_UNUSED, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
			'{STS_NOT_FOUND, 32'h0, 1'b0, 32'h0, 32'h0}},
		// largest port near the top of the address space
		'{'{OP_ALLOC, 32'hFFFF_FFF0, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
			'{STS_OK, 32'hFFFF_FFF0, 1'b0, 32'h0, 32'h0}},
		// arrival address wraps through zero, then completes, re-completes, overruns
		'{'{OP_STORE, 32'hFFFF_FFF0, 24'h00_0010, 32'h0, 32'h0}, 1'b0, NO_RSP},
		'{'{OP_STORE, 32'h0000_0000, 24'hFF_FFEF, 32'h0, 32'h0}, 1'b0, NO_RSP},
		'{'{OP_STORE, 32'h00FF_FFEF, 24'h00_0000, 32'h0, 32'h0}, 1'b0, NO_RSP},
		'{'{OP_STORE, 32'h00FF_FFEF, 24'h00_0001, 32'h0, 32'h0}, 1'b0, NO_RSP},
		// zero-size port completes on an empty store at its base
		'{'{OP_ALLOC, 32'h0, 24'h0, 32'h1234_5678, 32'hA5A5_A5A5}, 1'b1,
			'{STS_OK, 32'h0, 1'b0, 32'h0, 32'h0}},
		'{'{OP_STORE, 32'h0, 24'h0, 32'h0, 32'h0}, 1'b0, NO_RSP},
		// second port on the same base, the lower entry wins and overruns
		'{'{OP_ALLOC, 32'h0, 24'h8, 32'h0F0F_0F0F, 32'hF0F0_F0F0}, 1'b1,
			'{STS_OK, 32'h0, 1'b0, 32'h0, 32'h0}},
		'{'{OP_STORE, 32'h0, 24'h8, 32'h0, 32'h0}, 1'b0, NO_RSP},
		'{'{OP_FREE, 32'h0, 24'h0, 32'h0, 32'h0}, 1'b1,
			'{STS_OK, 32'h0, 1'b0, 32'h0, 32'h0}},
		// now the upper entry fills in two pieces
		'{'{OP_STORE, 32'h0, 24'h3, 32'h0, 32'h0}, 1'b0, NO_RSP},
		'{'{OP_STORE, 32'h3, 24'h5, 32'h0, 32'h0}, 1'b0, NO_RSP},
		'{'{OP_FREE, 32'h0, 24'h0, 32'h0, 32'h0}, 1'b1,
			'{STS_OK, 32'h0, 1'b0, 32'h0, 32'h0}},
		'{'{OP_FREE, 32'h0, 24'h0, 32'h0, 32'h0}, 1'b1,
			'{STS_NOT_FOUND, 32'h0, 1'b0, 32'h0, 32'h0}},
		// store with no matching port while another is live
		'{'{OP_STORE, 32'h5555_5555, 24'hAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b1,
			'{STS_NOT_FOUND, 32'h0, 1'b0, 32'h0, 32'h0}},
		'{'{OP_ALLOC, 32'hAAAA_AAAA, 24'h55_5555, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b1,
			'{STS_OK, 32'hAAAA_AAAA, 1'b0, 32'h0, 32'h0}},
		'{'{OP_STORE, 32'hAAAA_AAAA, 24'h55_5555, 32'h0, 32'h0}, 1'b0, NO_RSP},
		'{'{OP_FREE, 32'hAAAA_AAAA, 24'h0, 32'h0, 32'h0}, 1'b1,
			'{STS_OK, 32'hAAAA_AAAA, 1'b0, 32'h0, 32'h0}},
		'{'{OP_FREE, 32'hFFFF_FFF0, 24'h0, 32'h0, 32'h0}, 1'b1,
			'{STS_OK, 32'hFFFF_FFF0, 1'b0, 32'h0, 32'h0}},
		'{'{OP_UNUSED, 32'h0, 24'h0, 32'h0, 32'h0}, 1'b1,
			'{STS_NOT_FOUND, 32'h0, 1'b0, 32'h0, 32'h0}}
	};

	logic clk = 1'b0;
	logic arst_n;

	// receiver ready as drawn per item, and the long hold-off on top of it
	logic rsp_ready_draw;
	logic pressure_hold = 1'b0;

	rpct_req_if req_ch ();
	rpct_rsp_if rsp_ch ();

	assign rsp_ch.ready = rsp_ready_draw && !pressure_hold;

	receive_port_completion_table_top #(
		.NUM_PORTS(NUM_PORTS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// bench copy of the port table
	logic              port_live     [NUM_PORTS];
	logic [ADDR_W-1:0] port_base     [NUM_PORTS];
	logic [LEN_W-1:0]  port_received [NUM_PORTS];
	logic [LEN_W-1:0]  port_expected [NUM_PORTS];
	logic [TAG_W-1:0]  port_handler  [NUM_PORTS];
	logic [TAG_W-1:0]  port_context  [NUM_PORTS];

	rsp_item_t   pending_results [$];
	int unsigned fail_count   = 0;
	int unsigned results_seen = 0;

	initial begin
		for (int k = 0; k < NUM_PORTS; k++) port_live[k] = 1'b0;
	end

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_CYCLES * 10);
		$display("tb_top: FAIL");
		$finish;
	end

	// long receiver hold-off, counted in cycles
	initial begin
		wait (arst_n === 1'b1);
		repeat (PRESSURE_AT) @(negedge clk);
		pressure_hold <= 1'b1;
		repeat (PRESSURE_CYCLES) @(negedge clk);
		pressure_hold <= 1'b0;
	end

	// applies one accepted item to the bench table, returns its result
	function automatic rsp_item_t predict_port_result(req_item_t it);
		rsp_item_t     r;
		logic          found;
		logic [LEN_W:0] total;
		r = '0;
		r.status = STS_NOT_FOUND;
		found = 1'b0;
		case (it.op)
			OP_ALLOC: begin
				r.status = STS_FULL;
				for (int k = 0; k < NUM_PORTS; k++) begin
					if (!found && !port_live[k]) begin
						found            = 1'b1;
						port_live[k]     = 1'b1;
						port_base[k]     = it.address;
						port_received[k] = '0;
						port_expected[k] = it.byte_len;
						port_handler[k]  = it.handler_tag;
						port_context[k]  = it.user_context;
						r.status         = STS_OK;
						r.port_id        = it.address;
					end
				end
			end
			OP_STORE: begin
				for (int k = 0; k < NUM_PORTS; k++) begin
					// end address of the port wraps at 32 bits
					if (!found && port_live[k] &&
					    port_base[k] + 32'(port_received[k]) == it.address) begin
						found     = 1'b1;
						total     = {1'b0, port_received[k]} + {1'b0, it.byte_len};
						r.port_id = port_base[k];
						if (total > {1'b0, port_expected[k]}) begin
							r.status = STS_OVERRUN;
						end else begin
							r.status         = STS_OK;
							port_received[k] = total[LEN_W-1:0];
							if (total == {1'b0, port_expected[k]}) begin
								r.complete     = 1'b1;
								r.done_handler = port_handler[k];
								r.done_context = port_context[k];
							end
						end
					end
				end
			end
			OP_FREE: begin
				for (int k = 0; k < NUM_PORTS; k++) begin
					if (!found && port_live[k] && port_base[k] == it.address) begin
						found        = 1'b1;
						port_live[k] = 1'b0;
						r.status     = STS_OK;
						r.port_id    = it.address;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// idle cycles before an item, with idle-free stretches every 200 items
	function automatic int unsigned draw_idle(int unsigned n);
		if (n % 200 < 40) return 0;
		return $urandom_range(0, 17);
	endfunction

	// random item shaped by the live ports of the bench table;
	// items 400..599 mostly allocate to run the table full, 600..799 drain it
	function automatic req_item_t draw_request(int unsigned n);
		req_item_t        it;
		int               live_idx [$];
		int               k;
		int unsigned      roll;
		int unsigned      alloc_w;
		int unsigned      store_w;
		int unsigned      free_w;
		logic [LEN_W-1:0] left;
		it.op           = OP_UNUSED;
		it.address      = $urandom;
		it.byte_len     = LEN_W'($urandom);
		it.handler_tag  = $urandom;
		it.user_context = $urandom;
		for (int j = 0; j < NUM_PORTS; j++) if (port_live[j]) live_idx.push_back(j);
		if (n >= 400 && n < 600) begin
			alloc_w = 85; store_w = 8;  free_w = 5;
		end else if (n >= 600 && n < 800) begin
			alloc_w = 5;  store_w = 30; free_w = 60;
		end else begin
			alloc_w = 25; store_w = 50; free_w = 20;
		end
		roll = $urandom_range(0, 99);
		if (roll < alloc_w) begin
			it.op = OP_ALLOC;
			// mostly small ports so that they complete, a few at any size
			case ($urandom_range(0, 19))
				0:       it.byte_len = LEN_W'($urandom);
				1, 2, 3: it.byte_len = LEN_W'($urandom_range(0, 4096));
				default: it.byte_len = LEN_W'($urandom_range(0, 64));
			endcase
			// now and then reuse a live base
			if (live_idx.size() > 0 && $urandom_range(0, 9) == 0)
				it.address = port_base[live_idx[$urandom_range(0, live_idx.size() - 1)]];
		end else if (roll < alloc_w + store_w) begin
			it.op = OP_STORE;
			// chunk at the end of a live port, now and then too long, else a stray address
			if (live_idx.size() > 0 && $urandom_range(0, 9) != 0) begin
				k          = live_idx[$urandom_range(0, live_idx.size() - 1)];
				it.address = port_base[k] + 32'(port_received[k]);
				left       = port_expected[k] - port_received[k];
				if ($urandom_range(0, 9) == 0)
					it.byte_len = left + 24'($urandom_range(1, 16));
				else if ($urandom_range(0, 2) == 0)
					it.byte_len = left;
				else
					it.byte_len = LEN_W'($urandom_range(0, left));
			end
		end else if (roll < alloc_w + store_w + free_w) begin
			it.op = OP_FREE;
			if (live_idx.size() > 0 && $urandom_range(0, 19) != 0)
				it.address = port_base[live_idx[$urandom_range(0, live_idx.size() - 1)]];
		end
		return it;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance;
	// valid stays up between back-to-back items
	task automatic offer_request(input req_item_t it, input int unsigned gap,
	                             input logic typed, input rsp_item_t typed_rsp);
		rsp_item_t predicted;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.op           <= it.op;
		req_ch.address      <= it.address;
		req_ch.byte_len     <= it.byte_len;
		req_ch.handler_tag  <= it.handler_tag;
		req_ch.user_context <= it.user_context;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		// accepted at this edge, the table moves on even for hand-typed rows
		predicted = predict_port_result(it);
		pending_results.push_back(typed ? typed_rsp : predicted);
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// request side: reset, directed table, random traffic, drain
	initial begin
		req_item_t item;
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.op           <= OP_ALLOC;
		req_ch.address      <= '0;
		req_ch.byte_len     <= '0;
		req_ch.handler_tag  <= '0;
		req_ch.user_context <= '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < DIR_N; r++) begin
			offer_request(DIRECTED_ROWS[r].stim, draw_idle(r),
			              DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			item = draw_request(n);
			offer_request(item, draw_idle(DIR_N + n), 1'b0, NO_RSP);
		end
		req_ch.valid <= 1'b0;

		// all results in, then a wait for stray result items
		while (pending_results.size() != 0) @(posedge clk);
		repeat (NUM_PORTS + 8) @(posedge clk);

		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// result side: random stalls, in-order checking
	initial begin
		int unsigned hold;
		rsp_item_t   want;
		rsp_ready_draw <= 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			hold = draw_idle(results_seen);
			if (hold > 0) begin
				rsp_ready_draw <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			rsp_ready_draw <= 1'b1;
			@(posedge clk);
			while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clk);
			if (pending_results.size() == 0) begin
				$display("%0t: result item with nothing expected, got status %h port %h",
				         $time, rsp_ch.status, rsp_ch.port_id);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status",       32'(want.status),   32'(rsp_ch.status));
				check_field("port_id",      want.port_id,       rsp_ch.port_id);
				check_field("complete",     32'(want.complete), 32'(rsp_ch.complete));
				check_field("done_handler", want.done_handler,  rsp_ch.done_handler);
				check_field("done_context", want.done_context,  rsp_ch.done_context);
			end
			results_seen++;
			@(negedge clk);
		end
	end

endmodule
